FILE: hw/rtl/pcu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcu_pkg
// Shared types and constants for the pearson correlation unit.
// ----------------------------------------------------------------------------
package pcu_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int MAX_SAMPLES = 4096;
   localparam int FRAC_BITS   = 15;
   localparam int CNT_W       = 13;
   localparam int SUM_W       = 29;
   localparam int SXY_W       = 44;
   localparam int SXX_W       = 43;
   localparam int PROD_W      = 2 * SAMPLE_W;
   localparam int CORR_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int WORD_W      = 64;
   localparam int ITER        = 64;
   localparam int STEP_W      = 6;
   localparam int DIV_STEPS   = FRAC_BITS + 1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DEGENERATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW   = 2'd2;

   localparam logic [CORR_W-1:0] CORR_MAX = 16'h7FFF;
   localparam logic [CORR_W-1:0] CORR_MIN = 16'h8000;

   typedef enum logic [2:0] {
      OP_N_SXY  = 3'd0,
      OP_SX_SY  = 3'd1,
      OP_N_SXX  = 3'd2,
      OP_SX_SX  = 3'd3,
      OP_N_SYY  = 3'd4,
      OP_SY_SY  = 3'd5,
      OP_DX_DY  = 3'd6
   } mul_op_type;

   typedef struct packed {
      logic       accept;
      logic       mul_load;
      logic       mul_step;
      logic       store;
      logic       sqrt_load;
      logic       sqrt_step;
      logic       div_load;
      logic       div_step;
      logic       finish;
      mul_op_type op;
   } cmd_type;

   typedef struct packed {
      logic step_last;
   } stat_type;

endpackage

FILE: hw/rtl/pcu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcu_ctrl
// Sequencer: accumulation, product sequence, square root, divide, output.
// ----------------------------------------------------------------------------
module pcu_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last_pair,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pcu_pkg::cmd_type cmd,
   input  pcu_pkg::stat_type stat
);

   typedef enum logic [9:0] {
      ST_ACCUM = 10'b0000000001,
      ST_DRAIN = 10'b0000000010,
      ST_LOAD  = 10'b0000000100,
      ST_MUL   = 10'b0000001000,
      ST_STORE = 10'b0000010000,
      ST_SQRT  = 10'b0000100000,
      ST_DIVLD = 10'b0001000000,
      ST_DIV   = 10'b0010000000,
      ST_FIN   = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type           state_ff, state_in;
   pcu_pkg::mul_op_type op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         op_ff    <= pcu_pkg::OP_N_SXY;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cmd       = '0;
      cmd.op    = op_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_last_pair) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            op_in    = pcu_pkg::OP_N_SXY;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (stat.step_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (op_ff == pcu_pkg::OP_DX_DY) begin
               cmd.sqrt_load = 1'b1;
               state_in      = ST_SQRT;
            end else begin
               cmd.store = 1'b1;
               state_in  = ST_LOAD;
               unique case (op_ff)
                  pcu_pkg::OP_N_SXY: op_in = pcu_pkg::OP_SX_SY;
                  pcu_pkg::OP_SX_SY: op_in = pcu_pkg::OP_N_SXX;
                  pcu_pkg::OP_N_SXX: op_in = pcu_pkg::OP_SX_SX;
                  pcu_pkg::OP_SX_SX: op_in = pcu_pkg::OP_N_SYY;
                  pcu_pkg::OP_N_SYY: op_in = pcu_pkg::OP_SY_SY;
                  default:           op_in = pcu_pkg::OP_DX_DY;
               endcase
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (stat.step_last) begin
               state_in = ST_DIVLD;
            end
         end
         ST_DIVLD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.step_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

endmodule

FILE: hw/rtl/pcu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcu_datapath
// Running sums, shift-add multiplier, digit square root and fraction divider.
// ----------------------------------------------------------------------------
module pcu_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  pcu_pkg::cmd_type                  cmd,
   output pcu_pkg::stat_type                 stat,
   input  logic signed [pcu_pkg::SAMPLE_W-1:0] req_x_sample,
   input  logic signed [pcu_pkg::SAMPLE_W-1:0] req_y_sample,
   output logic signed [pcu_pkg::CORR_W-1:0]   rsp_correlation,
   output logic [pcu_pkg::STATUS_W-1:0]        rsp_status,
   output logic [pcu_pkg::CNT_W-1:0]           rsp_pairs_used
);

   localparam int W  = pcu_pkg::WORD_W;
   localparam int W2 = 2 * pcu_pkg::WORD_W;

   // pending products, added to the sums in the cycle after the word is taken
   logic                              pend_ff, pend_in;
   logic signed [pcu_pkg::SAMPLE_W-1:0] px_ff, py_ff;
   logic signed [pcu_pkg::PROD_W-1:0]   pxy_ff, pxx_ff, pyy_ff;

   logic [pcu_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                             ovf_ff, ovf_in;
   logic signed [pcu_pkg::SUM_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [pcu_pkg::SXY_W-1:0] sxy_ff, sxy_in;
   logic [pcu_pkg::SXX_W-1:0]        sxx_ff, sxx_in, syy_ff, syy_in;
   logic                             keep;

   logic [W2-1:0]  ma_ff, macc_ff;
   logic [W-1:0]   mb_ff;
   logic [W-1:0]   op_a, op_b;
   logic [W-1:0]   pa_ff, num_ff, dx_ff, dy_ff;

   logic [W2-1:0]  rad_ff;
   logic [W+1:0]   rem_ff, rem_sh, trial;
   logic [W-1:0]   root_ff;
   logic           sq_ge;

   logic [W:0]     dr_ff, dr_t;
   logic [pcu_pkg::CORR_W-1:0] q_ff;
   logic           dv_ge;
   logic [pcu_pkg::STEP_W-1:0] step_ff;

   logic           neg, degen;
   logic [W-1:0]   mag;
   logic [pcu_pkg::CORR_W-1:0]   corr_val;
   logic [pcu_pkg::STATUS_W-1:0] status_val;

   logic signed [pcu_pkg::CORR_W-1:0] corr_ff;
   logic [pcu_pkg::STATUS_W-1:0]      status_ff;
   logic [pcu_pkg::CNT_W-1:0]         pairs_ff;

   assign keep = cnt_ff < pcu_pkg::CNT_W'(pcu_pkg::MAX_SAMPLES);

   always_comb begin
      pend_in = cmd.accept && keep;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      sxy_in  = sxy_ff;
      sxx_in  = sxx_ff;
      syy_in  = syy_ff;
      if (cmd.accept) begin
         if (keep) begin
            cnt_in = cnt_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (pend_ff) begin
         sx_in  = sx_ff + pcu_pkg::SUM_W'(px_ff);
         sy_in  = sy_ff + pcu_pkg::SUM_W'(py_ff);
         sxy_in = sxy_ff + pcu_pkg::SXY_W'(pxy_ff);
         sxx_in = sxx_ff + pcu_pkg::SXX_W'($unsigned(pxx_ff));
         syy_in = syy_ff + pcu_pkg::SXX_W'($unsigned(pyy_ff));
      end
      if (cmd.finish) begin
         cnt_in = '0;
         ovf_in = 1'b0;
         sx_in  = '0;
         sy_in  = '0;
         sxy_in = '0;
         sxx_in = '0;
         syy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         sx_ff   <= '0;
         sy_ff   <= '0;
         sxy_ff  <= '0;
         sxx_ff  <= '0;
         syy_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         sxy_ff  <= sxy_in;
         sxx_ff  <= sxx_in;
         syy_ff  <= syy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff  <= req_x_sample;
         py_ff  <= req_y_sample;
         pxy_ff <= req_x_sample * req_y_sample;
         pxx_ff <= req_x_sample * req_x_sample;
         pyy_ff <= req_y_sample * req_y_sample;
      end
   end

   // operands, sign extended so the low word of the product wraps correctly
   always_comb begin
      unique case (cmd.op)
         pcu_pkg::OP_N_SXY: begin
            op_a = W'(cnt_ff);
            op_b = W'(sxy_ff);
         end
         pcu_pkg::OP_SX_SY: begin
            op_a = W'(sx_ff);
            op_b = W'(sy_ff);
         end
         pcu_pkg::OP_N_SXX: begin
            op_a = W'(cnt_ff);
            op_b = W'(sxx_ff);
         end
         pcu_pkg::OP_SX_SX: begin
            op_a = W'(sx_ff);
            op_b = W'(sx_ff);
         end
         pcu_pkg::OP_N_SYY: begin
            op_a = W'(cnt_ff);
            op_b = W'(syy_ff);
         end
         pcu_pkg::OP_SY_SY: begin
            op_a = W'(sy_ff);
            op_b = W'(sy_ff);
         end
         default: begin
            op_a = dx_ff;
            op_b = dy_ff;
         end
      endcase
   end

   // square root: two radicand bits per step
   assign rem_sh = {rem_ff[W-1:0], rad_ff[W2-1:W2-2]};
   assign trial  = {root_ff, 2'b01};
   assign sq_ge  = rem_sh >= trial;

   // divide: first step takes the integer bit, the rest shift in fraction bits
   assign dr_t  = (step_ff == '0) ? dr_ff : {dr_ff[W-1:0], 1'b0};
   assign dv_ge = dr_t >= {1'b0, root_ff};

   assign stat.step_last = cmd.div_step ?
                           (step_ff == pcu_pkg::STEP_W'(pcu_pkg::DIV_STEPS - 1)) :
                           (step_ff == pcu_pkg::STEP_W'(pcu_pkg::ITER - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.mul_load || cmd.sqrt_load || cmd.div_load) begin
         step_ff <= '0;
      end else if (cmd.mul_step || cmd.sqrt_step || cmd.div_step) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         ma_ff   <= W2'(op_a);
         mb_ff   <= op_b;
         macc_ff <= '0;
      end else if (cmd.mul_step) begin
         if (mb_ff[0]) begin
            macc_ff <= macc_ff + ma_ff;
         end
         ma_ff <= {ma_ff[W2-2:0], 1'b0};
         mb_ff <= {1'b0, mb_ff[W-1:1]};
      end
      if (cmd.store) begin
         case (cmd.op)
            pcu_pkg::OP_SX_SY: num_ff <= pa_ff - macc_ff[W-1:0];
            pcu_pkg::OP_SX_SX: dx_ff  <= pa_ff - macc_ff[W-1:0];
            pcu_pkg::OP_SY_SY: dy_ff  <= pa_ff - macc_ff[W-1:0];
            default:           pa_ff  <= macc_ff[W-1:0];
         endcase
      end
      if (cmd.sqrt_load) begin
         rad_ff  <= macc_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff  <= {rad_ff[W2-3:0], 2'b00};
         rem_ff  <= sq_ge ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[W-2:0], sq_ge};
      end
      if (cmd.div_load) begin
         dr_ff <= {1'b0, mag};
         q_ff  <= '0;
      end else if (cmd.div_step) begin
         dr_ff <= dv_ge ? (dr_t - {1'b0, root_ff}) : dr_t;
         q_ff  <= {q_ff[pcu_pkg::CORR_W-2:0], dv_ge};
      end
   end

   assign neg   = num_ff[W-1];
   assign mag   = neg ? (W'(0) - num_ff) : num_ff;
   assign degen = (dx_ff == '0) || (dy_ff == '0);

   always_comb begin
      if (degen) begin
         corr_val   = '0;
         status_val = pcu_pkg::STATUS_DEGENERATE;
      end else begin
         status_val = ovf_ff ? pcu_pkg::STATUS_OVERFLOW : pcu_pkg::STATUS_OK;
         if (neg) begin
            corr_val = q_ff[pcu_pkg::CORR_W-1] ? pcu_pkg::CORR_MIN :
                       (pcu_pkg::CORR_W'(0) - q_ff);
         end else begin
            corr_val = (q_ff >= pcu_pkg::CORR_MAX) ? pcu_pkg::CORR_MAX : q_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         corr_ff   <= $signed(corr_val);
         status_ff <= status_val;
         pairs_ff  <= cnt_ff;
      end
   end

   assign rsp_correlation = corr_ff;
   assign rsp_status      = status_ff;
   assign rsp_pairs_used  = pairs_ff;

endmodule

FILE: hw/rtl/pearson_correlation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pearson_correlation_unit
// Streams (x, y) pairs into running sums; on the last pair forms the
// correlation coefficient in Q1.15 with exact integer arithmetic.
// ----------------------------------------------------------------------------
//  channel  | ports                                        | direction
//  req      | req_valid req_stall req_x_sample             | in
//           | req_y_sample req_last_pair                   |
//  rsp      | rsp_valid rsp_stall rsp_correlation          | out
//           | rsp_status rsp_pairs_used                    |
//
// one pair per cycle while accumulating
// the last pair starts seven 64-step shift-add products,
// a 64-step square root and a 16-step divide, all on one sequencer
// input is stalled from the last pair until its result word is taken
// synchronous reset clears the sums, the count and the controller
// ----------------------------------------------------------------------------
module pearson_correlation_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [pcu_pkg::SAMPLE_W-1:0] req_x_sample,
   input  logic signed [pcu_pkg::SAMPLE_W-1:0] req_y_sample,
   input  logic                                req_last_pair,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pcu_pkg::CORR_W-1:0]   rsp_correlation,
   output logic [pcu_pkg::STATUS_W-1:0]        rsp_status,
   output logic [pcu_pkg::CNT_W-1:0]           rsp_pairs_used
);

   pcu_pkg::cmd_type  cmd;
   pcu_pkg::stat_type stat;

   pcu_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_pair (req_last_pair),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .stat          (stat)
   );

   pcu_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_x_sample    (req_x_sample),
      .req_y_sample    (req_y_sample),
      .rsp_correlation (rsp_correlation),
      .rsp_status      (rsp_status),
      .rsp_pairs_used  (rsp_pairs_used)
   );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pearson_correlation_unit testbench
// Sends series of (x, y) pairs through the correlation unit. A directed table
// covers extremes, degenerate series and pair overflow. Random series follow.
// Each result is checked against the typed table value or a bit-exact integer
// correlation computed here. Both interface sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 700;
   localparam int RANDOM_PAIRS = 1200;

   typedef struct packed {
      logic signed [pcu_pkg::CORR_W-1:0] corr;
      logic [pcu_pkg::STATUS_W-1:0]      status;
      logic [pcu_pkg::CNT_W-1:0]         used;
   } result_type;

   typedef struct {
      int x;
      int y;
      bit last;
      int reps;
      bit typed;
      int corr;
      int status;
      int used;
   } plan_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic signed [pcu_pkg::SAMPLE_W-1:0] req_x_sample;
   logic signed [pcu_pkg::SAMPLE_W-1:0] req_y_sample;
   logic                                req_last_pair;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic signed [pcu_pkg::CORR_W-1:0]   rsp_correlation;
   logic [pcu_pkg::STATUS_W-1:0]        rsp_status;
   logic [pcu_pkg::CNT_W-1:0]           rsp_pairs_used;

   pearson_correlation_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_x_sample    (req_x_sample),
      .req_y_sample    (req_y_sample),
      .req_last_pair   (req_last_pair),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_correlation (rsp_correlation),
      .rsp_status      (rsp_status),
      .rsp_pairs_used  (rsp_pairs_used)
   );

   // running sums of the series in flight
   longint     acc_n, acc_x, acc_y, acc_xy, acc_xx, acc_yy;
   bit         acc_dropped;
   result_type pending_results[$];
   int         error_count;
   int         pairs_sent;
   int         series_sent;
   int         results_seen;
   int         cycle_count;
   int         burst_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic result_type correlate_series();
      result_type   res;
      longint       num, dx, dy;
      logic [127:0] prod, quot;
      logic [63:0]  root, cand, mag;
      res.used = acc_n[pcu_pkg::CNT_W-1:0];
      res.corr = '0;
      num = acc_n * acc_xy - acc_x * acc_y;
      dx  = acc_n * acc_xx - acc_x * acc_x;
      dy  = acc_n * acc_yy - acc_y * acc_y;
      if (dx == 0 || dy == 0) begin
         res.status = pcu_pkg::STATUS_DEGENERATE;
      end else begin
         res.status = acc_dropped ? pcu_pkg::STATUS_OVERFLOW : pcu_pkg::STATUS_OK;
         prod = {64'd0, dx} * {64'd0, dy};
         root = '0;
         for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= prod) root = cand;
         end
         mag  = (num < 0) ? -num : num;
         quot = ({64'd0, mag} << pcu_pkg::FRAC_BITS) / {64'd0, root};
         if (num < 0)
            res.corr = (quot >= 128'd32768) ? pcu_pkg::CORR_MIN :
                       -quot[pcu_pkg::CORR_W-1:0];
         else
            res.corr = (quot >= 128'd32767) ? pcu_pkg::CORR_MAX :
                       quot[pcu_pkg::CORR_W-1:0];
      end
      return res;
   endfunction

   function automatic void clear_series();
      acc_n = 0; acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
      acc_dropped = 1'b0;
   endfunction

   // folds one accepted word into the sums; returns the result if last
   function automatic bit absorb_pair(int x, int y, bit last, output result_type res);
      if (acc_n < pcu_pkg::MAX_SAMPLES) begin
         acc_n++;
         acc_x  += x;
         acc_y  += y;
         acc_xy += longint'(x) * y;
         acc_xx += longint'(x) * x;
         acc_yy += longint'(y) * y;
      end else begin
         acc_dropped = 1'b1;
      end
      if (!last) return 1'b0;
      res = correlate_series();
      clear_series();
      return 1'b1;
   endfunction

   // drives one word from a falling edge and waits for it to be taken
   task automatic send_pair(int x, int y, bit last, bit typed, result_type typed_res);
      result_type res;
      int         gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid     = 1'b1;
      req_x_sample  = x[pcu_pkg::SAMPLE_W-1:0];
      req_y_sample  = y[pcu_pkg::SAMPLE_W-1:0];
      req_last_pair = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pairs_sent++;
      if (absorb_pair(x, y, last, res)) begin
         series_sent++;
         pending_results.insert(pending_results.size(), typed ? typed_res : res);
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // receiver stall pattern: free-running, random, or long holds
   int stall_mode, stall_timer, stall_hold;
   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  <= $urandom_range(0, 2);
         stall_timer <= $urandom_range(20, 200);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= $urandom_range(0, 1);
         default: begin
            if (stall_hold == 0) begin
               stall_hold <= $urandom_range(1, 20);
               rsp_stall  <= ~rsp_stall;
            end else begin
               stall_hold <= stall_hold - 1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_correlation !== want.corr) begin
               $error("correlation expected %0d got %0d", want.corr, rsp_correlation);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_pairs_used !== want.used) begin
               $error("pairs_used expected %0d got %0d", want.used, rsp_pairs_used);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("pearson_correlation_unit test failed");
         $finish;
      end
   end

   plan_row_type plan [13] = '{
      // single pair: degenerate
      '{5, 5, 1'b1, 1, 1'b1, 0, pcu_pkg::STATUS_DEGENERATE, 1},
      // extremes, perfect positive then perfect negative
      '{-32768, -32768, 1'b0, 1, 1'b0, 0, 0, 0},
      '{32767, 32767, 1'b1, 1, 1'b1, 32767, pcu_pkg::STATUS_OK, 2},
      '{-32768, 32767, 1'b0, 1, 1'b0, 0, 0, 0},
      '{32767, -32768, 1'b1, 1, 1'b1, -32768, pcu_pkg::STATUS_OK, 2},
      // constant x series
      '{7, 1, 1'b0, 1, 1'b0, 0, 0, 0},
      '{7, 2, 1'b0, 1, 1'b0, 0, 0, 0},
      '{7, 3, 1'b1, 1, 1'b1, 0, pcu_pkg::STATUS_DEGENERATE, 3},
      // mixed values, predictor checked
      '{1000, -3, 1'b0, 1, 1'b0, 0, 0, 0},
      '{-20, 400, 1'b0, 1, 1'b0, 0, 0, 0},
      '{3, 3, 1'b1, 1, 1'b0, 0, 0, 0},
      // alternating 0/1 past the pair limit, last pair dropped
      '{0, 0, 1'b0, 4100, 1'b0, 0, 0, 0},
      '{100, 100, 1'b1, 1, 1'b1, 32767, pcu_pkg::STATUS_OVERFLOW, 4096}
   };

   initial begin
      result_type typed_res;
      int         len, style, x, y, slope, base;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_x_sample  = '0;
      req_y_sample  = '0;
      req_last_pair = 1'b0;
      rsp_stall     = 1'b0;
      stall_mode    = 0;
      stall_timer   = 0;
      stall_hold    = 0;
      error_count   = 0;
      pairs_sent    = 0;
      series_sent   = 0;
      results_seen  = 0;
      cycle_count   = 0;
      burst_left    = 0;
      clear_series();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         typed_res.corr   = plan[i].corr[pcu_pkg::CORR_W-1:0];
         typed_res.status = plan[i].status[pcu_pkg::STATUS_W-1:0];
         typed_res.used   = plan[i].used[pcu_pkg::CNT_W-1:0];
         for (int k = 0; k < plan[i].reps; k++)
            send_pair(plan[i].x + (k & 1), plan[i].y + (k & 1),
                      plan[i].last && k == plan[i].reps - 1, plan[i].typed, typed_res);
      end
      // exactly the pair limit, ending normally
      for (int k = 0; k < pcu_pkg::MAX_SAMPLES; k++)
         send_pair(k & 1, k & 1, k == pcu_pkg::MAX_SAMPLES - 1, 1'b0, typed_res);

      while (pairs_sent < 8300 + RANDOM_PAIRS) begin
         case ($urandom_range(0, 19))
            0:       len = 1;
            1:       len = $urandom_range(100, 300);
            default: len = $urandom_range(2, 24);
         endcase
         style = $urandom_range(0, 4);
         slope = $urandom_range(0, 6) - 3;
         base  = $urandom_range(0, 65535) - 32768;
         for (int k = 0; k < len; k++) begin
            x = $urandom_range(0, 65535) - 32768;
            y = $urandom_range(0, 65535) - 32768;
            case (style)
               1: begin
                  x = $urandom_range(0, 16) - 8;
                  y = $urandom_range(0, 16) - 8;
               end
               2: begin
                  // near-linear relation, clipped to the sample range
                  x = $urandom_range(0, 20000) - 10000;
                  y = slope * x + $urandom_range(0, 64) - 32;
                  if (y > 32767) y = 32767;
                  if (y < -32768) y = -32768;
               end
               3: x = base;
               4: begin
                  x = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
                  y = ($urandom_range(0, 1) == 1) ? x : -1 - x;
               end
               default: ;
            endcase
            send_pair(x, y, k == len - 1, 1'b0, typed_res);
         end
      end

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d pairs in %0d series, %0d result words checked",
               pairs_sent, series_sent, results_seen);
      $display("covered extremes, degenerate series, pair overflow and random stalls");
      if (error_count == 0 && pending_results.size() == 0)
         $display("pearson_correlation_unit test passed");
      else
         $display("pearson_correlation_unit test failed");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/pcu_pkg.sv
hw/rtl/pcu_ctrl.sv
hw/rtl/pcu_datapath.sv
hw/rtl/pearson_correlation_unit.sv
verif/testbench.sv
